// ===== rtl/core/itlu_pkg.sv =====
// Shared types and constants of the implicit-tree range lookup.
`default_nettype none
package itlu_pkg;

   localparam int COUNT_W   = 11;
   localparam int LOWER_W   = 21;
   localparam int LEN_W     = 11;
   localparam int ENTRY_W   = LOWER_W + LEN_W;
   localparam int PROP_W    = 8;
   localparam int SLOT_W    = 10;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [PROP_W-1:0]  NO_MATCH    = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // register index, taken from the word address of the CSR port
   localparam logic REG_TABLE_COUNT = 1'b0;

   typedef struct packed {
      logic                 action;
      logic [SLOT_W-1:0]    slot;
      logic [ENTRY_W-1:0]   range_word;
      logic [PROP_W-1:0]    property_value;
      logic [LOWER_W-1:0]   code_point;
   } itlu_req_type;

   typedef struct packed {
      logic [PROP_W-1:0] property_res;
      logic              found;
   } itlu_rsp_type;

   // outcome of comparing a code point against one tree node
   typedef struct packed {
      logic hit;
      logic go_left;
   } itlu_dec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } itlu_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/itlu_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module itlu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/itlu_node_cmp.sv =====
// Range test of one tree node against the code point being looked up.
`default_nettype none
module itlu_node_cmp (
   input  wire logic [itlu_pkg::ENTRY_W-1:0] entry,
   input  wire logic [itlu_pkg::LOWER_W-1:0] code_point,
   output itlu_pkg::itlu_dec_type            dec
);
   import itlu_pkg::*;

   logic [LOWER_W-1:0] lower;
   logic [LEN_W-1:0]   len;
   logic [LOWER_W-1:0] offset;
   logic               below;

   always_comb begin
      lower  = entry[LOWER_W-1:0];
      len    = entry[ENTRY_W-1:LOWER_W];
      below  = code_point < lower;
      offset = code_point - lower;
      // an empty range never hits and sends the walk right unless below
      dec.hit     = !below && (len != '0) && (offset < {{(LOWER_W-LEN_W){1'b0}}, len});
      dec.go_left = below;
   end

endmodule
`default_nettype wire

// ===== rtl/core/implicit_tree_range_lookup.sv =====
// Top level of the implicit-tree range lookup.
//
// Items arrive on req_* (valid/ready). A write item (action 0) stores one
// range entry and its property at the given tree slot and gives no result;
// slots at or above TABLE_DEPTH are dropped. A lookup item (action 1) walks
// the tree from node 1 and gives one result on rsp_*.
// The walk reads one node per cycle from the entry and property RAMs: the
// next node address is formed from the registered read data and sent
// straight back to the read port. A lookup visits at most log2 of the table
// depth nodes; the next item is taken as soon as the result has moved to the
// output register. With table_count at most 1 no node is visited.
// The result sits in an output register, so a stalled receiver holds only
// that register; a second finished lookup waits in the block until it frees.
// table_count is written through the csr_* port at byte address 0.
// Reset (synchronous) returns to idle, empties the output register and sets
// table_count to 1; table contents are undefined until written.
`default_nettype none
module implicit_tree_range_lookup #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire itlu_pkg::itlu_req_type        req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output itlu_pkg::itlu_rsp_type             rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [itlu_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [itlu_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [itlu_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import itlu_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   itlu_state_type       state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [LOWER_W-1:0]   cp_ff, cp_in;
   itlu_rsp_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   itlu_rsp_type         rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 accept;
   logic                 csr_wr;
   logic [CW-1:0]        count_ext;
   logic [CW-1:0]        limit;
   logic [CW-1:0]        slot_ext;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic [ENTRY_W-1:0]   entry_rd;
   logic [PROP_W-1:0]    prop_rd;
   itlu_dec_type         dec;
   logic [AW:0]          next_idx;
   logic                 next_out;
   logic                 out_free;
   logic                 load_rsp;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_AW-1] == REG_TABLE_COUNT);
   assign csr_prdata = {{(CSR_DW-COUNT_W){1'b0}}, count_ff};
   assign count_in   = csr_wr ? csr_pwdata[COUNT_W-1:0] : count_ff;

   assign count_ext = {{(CW-COUNT_W){1'b0}}, count_ff};
   assign limit     = (count_ext < DEPTH_C) ? count_ext : DEPTH_C;

   // ---------------------------------------------------------------- tables
   assign accept   = req_valid && req_ready;
   assign slot_ext = {{(CW-SLOT_W){1'b0}}, req_data.slot};
   assign wr_en    = accept && (req_data.action == ACT_WRITE) && (slot_ext < DEPTH_C);

   itlu_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_range_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_data.range_word),
      .rd_addr (rd_addr),
      .rd_data (entry_rd)
   );

   itlu_ram #(.WIDTH(PROP_W), .DEPTH(TABLE_DEPTH)) u_prop_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_data.property_value),
      .rd_addr (rd_addr),
      .rd_data (prop_rd)
   );

   itlu_node_cmp u_cmp (
      .entry      (entry_rd),
      .code_point (cp_ff),
      .dec        (dec)
   );

   assign next_idx = {idx_ff, ~dec.go_left};
   assign next_out = {{(CW-AW-1){1'b0}}, next_idx} >= limit;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == ACT_LOOKUP) begin
               state_in = (limit <= CW'(1)) ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (dec.hit || next_out) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = AW'(1);
      idx_in    = idx_ff;
      cp_in     = cp_ff;
      res_in    = res_ff;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // node 1 is read while idle so its data is ready on the first walk cycle
            req_ready = 1'b1;
            idx_in    = AW'(1);
            cp_in     = req_data.code_point;
            res_in    = '{property_res: NO_MATCH, found: 1'b0};
         end
         ST_WALK: begin
            if (dec.hit) begin
               res_in = '{property_res: prop_rd, found: 1'b1};
            end else if (next_out) begin
               res_in = '{property_res: NO_MATCH, found: 1'b0};
            end else begin
               idx_in  = next_idx[AW-1:0];
               rd_addr = next_idx[AW-1:0];
            end
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load_rsp ? res_ff : rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cp_ff       <= cp_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/itlu_checker.sv =====
// Port-level checks of the range lookup, bound to the top level.
`default_nettype none
module itlu_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire itlu_pkg::itlu_req_type      req_data,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire itlu_pkg::itlu_rsp_type      rsp_data
);
   import itlu_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.property_res == NO_MATCH)
      else $error("miss without the no-match property");

   // a lookup always leaves the block busy once it is taken
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACT_LOOKUP |=> !req_ready)
      else $error("item taken straight after a lookup");

endmodule

bind implicit_tree_range_lookup itlu_checker u_itlu_checker (.*);
`default_nettype wire

// ===== bench/implicit_tree_range_lookup_tb.sv =====
// Self-checking testbench for the implicit-tree range lookup.
`timescale 1ns / 100ps
module implicit_tree_range_lookup_tb;
   import itlu_pkg::*;

   localparam int unsigned DEPTH          = 1024;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int unsigned END_CYCLES     = 24;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam logic [CSR_AW-1:0] TABLE_COUNT_ADDR = CSR_AW'(4 * REG_TABLE_COUNT);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   itlu_req_type        req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   itlu_rsp_type        rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // shadow of the block's tables and register
   logic [ENTRY_W-1:0]  range_mem [DEPTH];
   logic [PROP_W-1:0]   prop_mem [DEPTH];
   logic [COUNT_W-1:0]  count_reg = COUNT_RESET;

   // scratch for building sorted trees
   logic [ENTRY_W-1:0]  sorted_words [DEPTH];
   logic [ENTRY_W-1:0]  tree_words [DEPTH];

   itlu_rsp_type        pending_lookups [$];
   itlu_rsp_type        oldest_lookup;
   int unsigned         mismatch_count = 0;
   int unsigned         quiet_cycles = 0;
   int unsigned         send_gap_pct = 0;
   int unsigned         recv_gap_pct = 0;

   implicit_tree_range_lookup #(
      .TABLE_DEPTH (DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // walk the shadow tree exactly as the block should
   function automatic itlu_rsp_type classify_code_point(logic [LOWER_W-1:0] cp);
      int unsigned         limit;
      int unsigned         node;
      logic [LOWER_W-1:0]  lo;
      logic [LEN_W-1:0]    len;
      itlu_rsp_type        outcome;
      limit = 32'(count_reg);
      if (limit > DEPTH)
         limit = DEPTH;
      node = 1;
      outcome.property_res = NO_MATCH;
      outcome.found = 1'b0;
      while (node < limit) begin
         lo  = range_mem[node][LOWER_W-1:0];
         len = range_mem[node][ENTRY_W-1:LOWER_W];
         if (cp < lo) begin
            node = 2 * node;
         end else if (len != '0 && (cp - lo) < len) begin
            outcome.property_res = prop_mem[node];
            outcome.found = 1'b1;
            return outcome;
         end else begin
            node = 2 * node + 1;
         end
      end
      return outcome;
   endfunction

   function automatic itlu_req_type scrambled_request();
      logic [95:0] bits;
      bits = {$urandom(), $urandom(), $urandom()};
      return bits[$bits(itlu_req_type)-1:0];
   endfunction

   // lay sorted entries into Eytzinger order by in-order traversal
   function automatic int place_inorder(int node, int last, int rank);
      if (node > last)
         return rank;
      rank = place_inorder(2 * node, last, rank);
      tree_words[node] = sorted_words[rank];
      return place_inorder(2 * node + 1, last, rank + 1);
   endfunction

   task automatic send_item(input itlu_req_type item);
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (item.action == ACT_WRITE) begin
         if (item.slot < DEPTH) begin
            range_mem[item.slot] = item.range_word;
            prop_mem[item.slot]  = item.property_value;
         end
      end else begin
         pending_lookups.push_back(classify_code_point(item.code_point));
      end
   endtask

   task automatic send_write(int unsigned slot, logic [ENTRY_W-1:0] word,
                             logic [PROP_W-1:0] prop);
      itlu_req_type item;
      item = scrambled_request();
      item.action         = ACT_WRITE;
      item.slot           = slot[SLOT_W-1:0];
      item.range_word     = word;
      item.property_value = prop;
      send_item(item);
   endtask

   task automatic send_lookup_at(logic [LOWER_W-1:0] cp);
      itlu_req_type item;
      item = scrambled_request();
      item.action     = ACT_LOOKUP;
      item.code_point = cp;
      send_item(item);
   endtask

   // mostly hits inside a tree node, some edges of ranges, some anywhere
   task automatic send_lookup(int unsigned last_node);
      int unsigned         node;
      int unsigned         pick;
      logic [LOWER_W-1:0]  lo;
      logic [LEN_W-1:0]    len;
      logic [LOWER_W-1:0]  cp;
      node = $urandom_range(1, last_node);
      pick = $urandom_range(0, 99);
      lo   = range_mem[node][LOWER_W-1:0];
      len  = range_mem[node][ENTRY_W-1:LOWER_W];
      if (pick < 60 && len != '0)
         cp = lo + LOWER_W'($urandom_range(0, int'(len) - 1));
      else if (pick < 80)
         cp = $urandom_range(0, 1) ? lo + LOWER_W'(len) : lo - LOWER_W'(1);
      else
         cp = LOWER_W'($urandom());
      send_lookup_at(cp);
   endtask

   task automatic send_noise_write();
      send_write($urandom_range(0, DEPTH - 1), $urandom(), PROP_W'($urandom()));
   endtask

   // stop sending and let every outstanding lookup come back
   task automatic drain(int unsigned settle);
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_lookups.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_table_count(int unsigned count);
      logic [CSR_DW-1:0] word;
      drain(SETTLE_CYCLES);
      word = $urandom();
      word[COUNT_W-1:0] = count[COUNT_W-1:0];
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= TABLE_COUNT_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      count_reg = word[COUNT_W-1:0];
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
   endtask

   // sorted, bucketed lower bounds so the tree is a valid search tree
   task automatic build_tree(int unsigned nodes);
      int unsigned         span;
      logic [LOWER_W-1:0]  lo;
      logic [LEN_W-1:0]    len;
      span = (1 << LOWER_W) / nodes;
      for (int r = 0; r < nodes; r++) begin
         lo  = LOWER_W'(r * span + $urandom_range(0, span - 1));
         len = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(1, 2047));
         sorted_words[r] = {len, lo};
      end
      void'(place_inorder(1, nodes, 0));
      for (int s = 1; s <= nodes; s++)
         send_write(s, tree_words[s], PROP_W'($urandom()));
   endtask

   // nothing written yet: the walk must stop before reading any node
   task automatic test_empty_table();
      send_lookup_at('0);
      send_lookup_at('1);
      set_table_count(0);
      send_lookup_at(21'h10FFFF);
   endtask

   task automatic test_directed_tree();
      logic [LOWER_W-1:0] probes [13] = '{
         21'd0, 21'd1, 21'd99, 21'd100, 21'd200, 21'd2246, 21'd2247,
         21'h10000, 21'h1000F, 21'h10010, 21'h10FFFF, 21'h1FFFFE, 21'h1FFFFF};
      // slot zero is never visited by a walk
      send_write(0, 32'hFFFF_FFFF, 8'h77);
      send_write(4, {11'd1,    21'd0},        8'h00);
      send_write(2, {11'd0,    21'd100},      8'h11);   // empty range
      send_write(5, {11'd2047, 21'd200},      8'hFF);   // found, yet property 255
      send_write(1, {11'd16,   21'h10000},    8'h5A);
      send_write(6, {11'd16,   21'h10FFF0},   8'hA5);
      send_write(3, {11'h400,  21'h180000},   8'h3C);
      send_write(7, 32'hFFFF_FFFF,            8'h80);
      set_table_count(8);
      foreach (probes[i])
         send_lookup_at(probes[i]);
      // shallower walk limit cuts both sides off early
      set_table_count(4);
      send_lookup_at('0);
      send_lookup_at('1);
   endtask

   task automatic test_full_tree();
      build_tree(DEPTH - 1);
      set_table_count(DEPTH);
      repeat (40) send_lookup(DEPTH - 1);
      // count beyond the table: walk is bounded by the depth
      set_table_count(2047);
      repeat (25) send_lookup(DEPTH - 1);
   endtask

   task automatic test_random_rounds();
      int unsigned nodes;
      int unsigned count;
      for (int round = 0; round < 3; round++) begin
         nodes = (1 << $urandom_range(2, 6)) - 1;
         build_tree(nodes);
         case (round)
            0: begin
               count = nodes + 1;
            end
            1: begin
               count = $urandom_range(1, nodes + 1);
            end
            default: begin
               count = $urandom_range(nodes + 1, 2047);
            end
         endcase
         set_table_count(count);
         for (int i = 0; i < 45; i++) begin
            if (round == 1 && i == 22)
               drain(0);
            if ($urandom_range(0, 9) == 0)
               send_noise_write();
            else
               send_lookup(nodes);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result: property_res %0d found %0d",
                   rsp_data.property_res, rsp_data.found);
            mismatch_count++;
         end else begin
            oldest_lookup = pending_lookups.pop_front();
            if (rsp_data.property_res !== oldest_lookup.property_res) begin
               $error("property_res: expected %0d, got %0d",
                      oldest_lookup.property_res, rsp_data.property_res);
               mismatch_count++;
            end
            if (rsp_data.found !== oldest_lookup.found) begin
               $error("found: expected %0d, got %0d",
                      oldest_lookup.found, rsp_data.found);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(21, 75);
      test_empty_table();
      test_directed_tree();
      test_full_tree();
      test_random_rounds();
      set_idling(75, 21);
      test_random_rounds();
      set_idling(0, 0);
      test_random_rounds();
      drain(END_CYCLES);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
